>>> hw/rtl/dd_pkg.sv
// ----------------------------------------------------------------------------
// dd_pkg
// Shared types, constants and calendar tables for the date difference unit.
// ----------------------------------------------------------------------------
`default_nettype none

package dd_pkg;

  localparam int YEAR_LIMIT_DEF = 9999;

  localparam int DAY_W   = 5;
  localparam int MONTH_W = 4;
  localparam int YEAR_W  = 14;
  localparam int COUNT_W = 22;
  localparam int ORDER_W = 2;

  // Shifted year (year + 400, minus one for January and February).
  localparam int YY_W   = YEAR_W + 1;
  // Days into the March-based year plus day of month minus one.
  localparam int DOFF_W = 9;
  // Day number width.
  localparam int DNUM_W = 23;

  // Divide by 100 through multiply by 5243 and shift by 19; exact below 43690.
  localparam int DIV100_MUL   = 5243;
  localparam int DIV100_SHIFT = 19;
  localparam int DIV100_W     = 13;
  localparam int DAYS_PER_YEAR = 365;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  localparam logic [ORDER_W-1:0] ORD_EQUAL         = 2'd0;
  localparam logic [ORDER_W-1:0] ORD_FIRST_LATER   = 2'd1;
  localparam logic [ORDER_W-1:0] ORD_FIRST_EARLIER = 2'd2;

  typedef struct packed {
    logic [DAY_W-1:0]   first_day;
    logic [MONTH_W-1:0] first_month;
    logic [YEAR_W-1:0]  first_year;
    logic [DAY_W-1:0]   second_day;
    logic [MONTH_W-1:0] second_month;
    logic [YEAR_W-1:0]  second_year;
  } in_item_t;

  typedef struct packed {
    logic [COUNT_W-1:0] day_count;
    logic [ORDER_W-1:0] order;
    logic               date_error;
  } out_item_t;

  typedef struct packed {
    logic s2_en;
    logic s3_en;
  } pipe_ctrl_t;

  // Days before the first of the month, counted from 1 March.
  function automatic logic [DOFF_W-1:0] month_offset(input logic [MONTH_W-1:0] m);
    logic [DOFF_W-1:0] r;
    case (m)
      4'd3:    r = 9'd0;
      4'd4:    r = 9'd31;
      4'd5:    r = 9'd61;
      4'd6:    r = 9'd92;
      4'd7:    r = 9'd122;
      4'd8:    r = 9'd153;
      4'd9:    r = 9'd184;
      4'd10:   r = 9'd214;
      4'd11:   r = 9'd245;
      4'd12:   r = 9'd275;
      4'd1:    r = 9'd306;
      4'd2:    r = 9'd337;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  function automatic logic [DAY_W-1:0] month_length(input logic [MONTH_W-1:0] m,
                                                    input logic leap);
    logic [DAY_W-1:0] r;
    case (m) inside
      4'd4, 4'd6, 4'd9, 4'd11: r = 5'd30;
      4'd2:                    r = leap ? 5'd29 : 5'd28;
      default:                 r = 5'd31;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/dd_check.sv
// ----------------------------------------------------------------------------
// dd_check
// Validates one date and prepares the shifted year and day offset.
// ----------------------------------------------------------------------------
`default_nettype none

module dd_check #(
  parameter int YEAR_LIMIT = dd_pkg::YEAR_LIMIT_DEF
) (
  input  wire logic [dd_pkg::DAY_W-1:0]   day,
  input  wire logic [dd_pkg::MONTH_W-1:0] month,
  input  wire logic [dd_pkg::YEAR_W-1:0]  year,
  output logic                            ok,
  output logic [dd_pkg::YY_W-1:0]         yy,
  output logic [dd_pkg::DOFF_W-1:0]       doff
);
  import dd_pkg::*;

  localparam int PROD_W = YEAR_W + DIV100_W;

  logic [PROD_W-1:0] q_prod;
  logic [7:0]        q100;
  logic [YEAR_W-1:0] hund;
  logic              by100;
  logic              leap;
  logic              month_ok;
  logic              year_ok;
  logic              day_ok;
  logic              early;

  assign q_prod = PROD_W'(year) * PROD_W'(DIV100_MUL);
  assign q100   = q_prod[DIV100_SHIFT +: 8];
  assign hund   = YEAR_W'({6'b0, q100} * 14'd100);
  assign by100  = (hund == year);
  // Leap on 4 unless on 100, then only on 400.
  assign leap   = (year[1:0] == 2'b00 && !by100) || (by100 && q100[1:0] == 2'b00);

  assign month_ok = month inside {[4'd1:4'd12]};
  assign year_ok  = (32'(year) <= 32'(YEAR_LIMIT));
  assign day_ok   = (day != '0) && (day <= month_length(month, leap));
  assign ok       = month_ok && year_ok && day_ok;

  assign early = (month <= 4'd2);
  assign yy    = {1'b0, year} + (early ? YY_W'(399) : YY_W'(400));
  assign doff  = month_offset(month) + DOFF_W'(day) - DOFF_W'(1);

endmodule

`default_nettype wire

>>> hw/rtl/dd_day_number.sv
// ----------------------------------------------------------------------------
// dd_day_number
// Two-stage day number: products and quotients, then the final sum.
// ----------------------------------------------------------------------------
`default_nettype none

module dd_day_number (
  input  wire logic                      clk,
  input  wire dd_pkg::pipe_ctrl_t        ctrl,
  input  wire logic [dd_pkg::YY_W-1:0]   yy,
  input  wire logic [dd_pkg::DOFF_W-1:0] doff,
  output logic [dd_pkg::DNUM_W-1:0]      dnum
);
  import dd_pkg::*;

  localparam int PROD_W = YY_W + DIV100_W;

  logic [PROD_W-1:0] prod;
  logic [DNUM_W-1:0] p365_r, p365_nxt;
  logic [8:0]        q100_r, q100_nxt;
  logic [YY_W-3:0]   q4_r, q4_nxt;
  logic [DOFF_W-1:0] doff_r;
  logic [DNUM_W-1:0] dnum_r, dnum_nxt;

  assign prod     = PROD_W'(yy) * PROD_W'(DIV100_MUL);
  assign q100_nxt = prod[DIV100_SHIFT +: 9];
  assign p365_nxt = DNUM_W'(yy) * DNUM_W'(DAYS_PER_YEAR);
  assign q4_nxt   = yy[YY_W-1:2];

  always_ff @(posedge clk) begin
    if (ctrl.s2_en) begin
      p365_r <= p365_nxt;
      q100_r <= q100_nxt;
      q4_r   <= q4_nxt;
      doff_r <= doff;
    end
  end

  // yy/400 is the quotient by 100 shifted down by two.
  assign dnum_nxt = p365_r + DNUM_W'(q4_r) - DNUM_W'(q100_r)
                  + DNUM_W'(q100_r[8:2]) + DNUM_W'(doff_r);

  always_ff @(posedge clk) begin
    if (ctrl.s3_en) begin
      dnum_r <= dnum_nxt;
    end
  end

  assign dnum = dnum_r;

endmodule

`default_nettype wire

>>> hw/rtl/dd_compare.sv
// ----------------------------------------------------------------------------
// dd_compare
// Orders two day numbers, forms the saturated difference, holds the result.
// ----------------------------------------------------------------------------
`default_nettype none

module dd_compare (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      s3_valid,
  input  wire logic                      s3_error,
  input  wire logic [dd_pkg::DNUM_W-1:0] dnum_a,
  input  wire logic [dd_pkg::DNUM_W-1:0] dnum_b,
  output logic                           s3_ready,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output dd_pkg::out_item_t              out_item
);
  import dd_pkg::*;

  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_item_r, out_item_nxt;
  logic              a_gt;
  logic              a_lt;
  logic [DNUM_W-1:0] diff;

  assign a_gt = dnum_a > dnum_b;
  assign a_lt = dnum_a < dnum_b;
  assign diff = a_gt ? (dnum_a - dnum_b) : (dnum_b - dnum_a);

  always_comb begin
    out_item_nxt = '0;
    if (s3_error) begin
      out_item_nxt.date_error = 1'b1;
    end else begin
      out_item_nxt.day_count = (diff > DNUM_W'(COUNT_MAX)) ? COUNT_MAX
                                                           : diff[COUNT_W-1:0];
      out_item_nxt.order     = a_gt ? ORD_FIRST_LATER :
                               a_lt ? ORD_FIRST_EARLIER : ORD_EQUAL;
    end
  end

  assign s3_ready      = !out_valid_r || !out_stall;
  assign out_valid_nxt = s3_ready ? s3_valid : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_ready) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_item_r.date_error |->
      out_item_r.day_count == '0 && out_item_r.order == ORD_EQUAL)
    else $error("error item carries a nonzero count or order");

  a_equal_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_item_r.order == ORD_EQUAL |-> out_item_r.day_count == '0)
    else $error("equal dates with nonzero count");

  a_unequal_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_item_r.order != ORD_EQUAL |->
      out_item_r.day_count != '0 && !out_item_r.date_error)
    else $error("ordered dates with zero count or error");

  a_order_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_item_r.order != 2'd3)
    else $error("unused order code");

endmodule

`default_nettype wire

>>> hw/rtl/date_difference_in_days_unit.sv
// ----------------------------------------------------------------------------
// date_difference_in_days_unit
// Days between two Gregorian dates, with their order and a bad-date flag.
// ----------------------------------------------------------------------------
//  channel | ports                          | payload
//  --------+--------------------------------+-------------------------------
//  input   | in_valid, in_stall, in_item    | two dates (day, month, year)
//  output  | out_valid, out_stall, out_item | day_count, order, date_error
//
// Four register stages: date check and year shift, constant products and
// the divide-by-100 quotient, day number sum, compare and output register.
// One item is accepted every cycle while in_stall is low.
// Synchronous active-low reset clears the stage valid bits only.
// A stage advances when it is empty or the next stage advances, so a held
// output lets bubbles in front of it fill up before the input stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module date_difference_in_days_unit #(
  parameter int YEAR_LIMIT = dd_pkg::YEAR_LIMIT_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire dd_pkg::in_item_t  in_item,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output dd_pkg::out_item_t      out_item
);
  import dd_pkg::*;

  logic              v1_r, v1_nxt;
  logic              v2_r, v2_nxt;
  logic              v3_r, v3_nxt;
  logic              err1_r, err2_r, err3_r;
  logic              rdy1, rdy2, rdy3, rdy_out;
  pipe_ctrl_t        ctrl;

  logic              ok_a, ok_b;
  logic [YY_W-1:0]   yy_a, yy_b;
  logic [DOFF_W-1:0] doff_a, doff_b;
  logic [YY_W-1:0]   yy_a_r, yy_b_r;
  logic [DOFF_W-1:0] doff_a_r, doff_b_r;
  logic [DNUM_W-1:0] dnum_a, dnum_b;

  dd_check #(.YEAR_LIMIT(YEAR_LIMIT)) u_check_a (
    .day   (in_item.first_day),
    .month (in_item.first_month),
    .year  (in_item.first_year),
    .ok    (ok_a),
    .yy    (yy_a),
    .doff  (doff_a)
  );

  dd_check #(.YEAR_LIMIT(YEAR_LIMIT)) u_check_b (
    .day   (in_item.second_day),
    .month (in_item.second_month),
    .year  (in_item.second_year),
    .ok    (ok_b),
    .yy    (yy_b),
    .doff  (doff_b)
  );

  // Ready chain from the output register back to the input.
  assign rdy3     = !v3_r || rdy_out;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_stall = !rdy1;

  assign ctrl.s2_en = rdy2;
  assign ctrl.s3_en = rdy3;

  assign v1_nxt = rdy1 ? in_valid : v1_r;
  assign v2_nxt = rdy2 ? v1_r : v2_r;
  assign v3_nxt = rdy3 ? v2_r : v3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      err1_r   <= !(ok_a && ok_b);
      yy_a_r   <= yy_a;
      yy_b_r   <= yy_b;
      doff_a_r <= doff_a;
      doff_b_r <= doff_b;
    end
    if (rdy2) begin
      err2_r <= err1_r;
    end
    if (rdy3) begin
      err3_r <= err2_r;
    end
  end

  dd_day_number u_dnum_a (
    .clk  (clk),
    .ctrl (ctrl),
    .yy   (yy_a_r),
    .doff (doff_a_r),
    .dnum (dnum_a)
  );

  dd_day_number u_dnum_b (
    .clk  (clk),
    .ctrl (ctrl),
    .yy   (yy_b_r),
    .doff (doff_b_r),
    .dnum (dnum_b)
  );

  dd_compare u_compare (
    .clk       (clk),
    .rst_n     (rst_n),
    .s3_valid  (v3_r),
    .s3_error  (err3_r),
    .dnum_a    (dnum_a),
    .dnum_b    (dnum_b),
    .s3_ready  (rdy_out),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> v1_r && v2_r && v3_r && out_valid)
    else $error("input stalled with a bubble in the pipe");

  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> v1_r)
    else $error("accepted item lost at stage one");

  a_hold_stage3: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r && !rdy3 |=> v3_r && $stable(err3_r))
    else $error("stage three changed while held");

endmodule

`default_nettype wire

>>> dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the date difference unit. Two Gregorian dates go in, and a day
// count, an order code and a bad-date flag come out. A scoreboard in this
// module computes each expected result from day numbers and compares it with
// the unit's output in order. Traffic covers calendar corners, well-formed
// date pairs, broken dates, raw bit noise and full-rate streaming, with
// random idling on both channels.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import dd_pkg::*;

  localparam int QUIET_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 8;

  typedef struct packed {
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
  } date_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_item;

  bit        in_gaps_on;
  bit        out_gaps_on;
  int        mismatches;
  int        quiet_cycles;
  out_item_t pending_gaps[$];

  date_difference_in_days_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Calendar arithmetic
  // --------------------------------------------------------------------------
  function automatic bit is_leap(int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int unsigned month_days(int unsigned m, int unsigned y);
    case (m)
      4, 6, 9, 11: return 30;
      2:           return is_leap(y) ? 29 : 28;
      default:     return 31;
    endcase
  endfunction

  function automatic bit date_valid(date_t dt);
    if (dt.month < 1 || dt.month > 12) return 1'b0;
    if (dt.year > YEAR_LIMIT_DEF) return 1'b0;
    return (dt.day >= 1) && (dt.day <= month_days(dt.month, dt.year));
  endfunction

  // Count days from a fixed epoch, with the year starting on 1 March.
  function automatic int unsigned day_serial(date_t dt);
    int unsigned yy;
    int unsigned mp;
    yy = dt.year + 400 - ((dt.month <= 2) ? 1 : 0);
    mp = (dt.month + 9) % 12;
    return 365 * yy + yy / 4 - yy / 100 + yy / 400 + (153 * mp + 2) / 5 + dt.day - 1;
  endfunction

  function automatic out_item_t date_gap(in_item_t it);
    date_t       a;
    date_t       b;
    out_item_t   r;
    int unsigned na;
    int unsigned nb;
    int unsigned span;
    a = '{it.first_day, it.first_month, it.first_year};
    b = '{it.second_day, it.second_month, it.second_year};
    r = '0;
    if (!date_valid(a) || !date_valid(b)) begin
      r.date_error = 1'b1;
      return r;
    end
    na = day_serial(a);
    nb = day_serial(b);
    if (na > nb) begin
      span = na - nb;
      r.order = ORD_FIRST_LATER;
    end else if (na < nb) begin
      span = nb - na;
      r.order = ORD_FIRST_EARLIER;
    end else begin
      span = 0;
      r.order = ORD_EQUAL;
    end
    r.day_count = (span > COUNT_MAX) ? COUNT_MAX : span[COUNT_W-1:0];
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Item generators
  // --------------------------------------------------------------------------
  function automatic in_item_t join_dates(date_t a, date_t b);
    in_item_t it;
    it.first_day    = a.day;
    it.first_month  = a.month;
    it.first_year   = a.year;
    it.second_day   = b.day;
    it.second_month = b.month;
    it.second_year  = b.year;
    return it;
  endfunction

  function automatic in_item_t dates_of(int unsigned d1, int unsigned m1, int unsigned y1,
                                        int unsigned d2, int unsigned m2, int unsigned y2);
    date_t a;
    date_t b;
    a = '{d1[DAY_W-1:0], m1[MONTH_W-1:0], y1[YEAR_W-1:0]};
    b = '{d2[DAY_W-1:0], m2[MONTH_W-1:0], y2[YEAR_W-1:0]};
    return join_dates(a, b);
  endfunction

  function automatic date_t random_date(int unsigned y_lo, int unsigned y_hi);
    date_t r;
    r.year  = YEAR_W'($urandom_range(y_hi, y_lo));
    r.month = MONTH_W'($urandom_range(12, 1));
    r.day   = DAY_W'($urandom_range(month_days(r.month, r.year), 1));
    return r;
  endfunction

  function automatic in_item_t well_formed_pair();
    date_t       a;
    date_t       b;
    int unsigned y;
    a = random_date(0, YEAR_LIMIT_DEF);
    case ($urandom_range(0, 3))
      0: b = random_date(0, YEAR_LIMIT_DEF);
      1: begin
        // keep the dates within a year or so of each other
        y = a.year;
        b = random_date((y == 0) ? 0 : y - 1, (y == YEAR_LIMIT_DEF) ? y : y + 1);
      end
      2: b = a;
      default: begin
        y = $urandom_range(0, 1) ? 0 : YEAR_LIMIT_DEF - 2;
        a = random_date(y, y + 2);
        b = random_date(y, y + 2);
      end
    endcase
    return $urandom_range(0, 1) ? join_dates(a, b) : join_dates(b, a);
  endfunction

  function automatic in_item_t broken_pair();
    date_t       a;
    date_t       b;
    date_t       bad;
    bit          pick;
    int unsigned len;
    a    = random_date(0, YEAR_LIMIT_DEF);
    b    = random_date(0, YEAR_LIMIT_DEF);
    pick = 1'($urandom_range(0, 1));
    bad  = pick ? a : b;
    len  = month_days(bad.month, bad.year);
    case ($urandom_range(0, 3))
      0: bad.month = $urandom_range(0, 1) ? '0 : MONTH_W'($urandom_range(15, 13));
      1: bad.day = '0;
      2: bad.day = (len < 31) ? DAY_W'($urandom_range(31, len + 1)) : '0;
      default: bad.year = YEAR_W'($urandom_range(2 ** YEAR_W - 1, YEAR_LIMIT_DEF + 1));
    endcase
    if (pick) a = bad;
    else b = bad;
    return join_dates(a, b);
  endfunction

  function automatic in_item_t noise_pair();
    logic [63:0] raw;
    raw = {$urandom(), $urandom()};
    return raw[$bits(in_item_t)-1:0];
  endfunction

  // --------------------------------------------------------------------------
  // Drive, stall, check
  // --------------------------------------------------------------------------
  task automatic send_dates(in_item_t it);
    if (in_gaps_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    pending_gaps.push_back(date_gap(it));
  endtask

  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_gaps_on && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 9)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic compare_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_gaps.size() == 0) begin
        $display("%0t: unexpected item, expected none, actual count %0d order %0d error %0d",
                 $time, out_item.day_count, out_item.order, out_item.date_error);
        mismatches++;
      end else begin
        want = pending_gaps.pop_front();
        compare_field("day_count", want.day_count, out_item.day_count);
        compare_field("order", want.order, out_item.order);
        compare_field("date_error", want.date_error, out_item.date_error);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: watchdog, no item moved for %0d cycles", $time, quiet_cycles);
      $display("Test completed with failures");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_directed_cases();
    in_gaps_on  = 1'b0;
    out_gaps_on = 1'b0;
    send_dates(dates_of(1, 1, 0, 31, 12, 9999));       // widest span
    send_dates(dates_of(31, 12, 9999, 1, 1, 0));
    send_dates(dates_of(15, 6, 2024, 15, 6, 2024));    // same date
    send_dates(dates_of(31, 12, 1999, 1, 1, 2000));
    send_dates(dates_of(29, 2, 2000, 1, 3, 2000));     // leap by 400
    send_dates(dates_of(29, 2, 1900, 1, 3, 1900));     // not leap by 100
    send_dates(dates_of(29, 2, 2024, 28, 2, 2023));
    send_dates(dates_of(29, 2, 2023, 1, 1, 2023));
    send_dates(dates_of(29, 2, 0, 1, 1, 0));           // year zero is leap
    send_dates(dates_of(28, 2, 2100, 29, 2, 2400));
    send_dates(dates_of(30, 9, 1752, 1, 10, 1752));
    send_dates(dates_of(31, 1, 9999, 30, 4, 9999));
    send_dates(dates_of(10, 0, 2020, 10, 5, 2020));    // month zero
    send_dates(dates_of(10, 5, 2020, 10, 13, 2020));
    send_dates(dates_of(31, 15, 16383, 31, 15, 16383));
    send_dates(dates_of(0, 7, 2020, 1, 7, 2020));      // day zero
    send_dates(dates_of(1, 7, 2020, 31, 4, 2020));     // past month end
    send_dates(dates_of(31, 11, 2020, 1, 1, 2020));
    send_dates(dates_of(1, 1, 10000, 1, 1, 9999));     // year past limit
    send_dates(dates_of(31, 12, 9999, 1, 1, 16383));
    send_dates(dates_of(0, 0, 0, 0, 0, 0));
  endtask

  task automatic test_valid_dates(int n);
    for (int i = 0; i < n; i++) begin
      if (i % 100 == 0) begin
        in_gaps_on  = 1'($urandom_range(0, 1));
        out_gaps_on = 1'($urandom_range(0, 1));
      end
      send_dates(well_formed_pair());
    end
  endtask

  task automatic test_bad_dates(int n);
    for (int i = 0; i < n; i++) begin
      if (i % 70 == 0) begin
        in_gaps_on  = 1'($urandom_range(0, 1));
        out_gaps_on = 1'($urandom_range(0, 1));
      end
      send_dates(($urandom_range(0, 2) == 0) ? noise_pair() : broken_pair());
    end
  endtask

  task automatic test_back_to_back(int n);
    int unsigned pick;
    in_gaps_on  = 1'b0;
    out_gaps_on = 1'b0;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 80) send_dates(well_formed_pair());
      else if (pick < 92) send_dates(broken_pair());
      else send_dates(noise_pair());
    end
  endtask

  initial begin
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_item  <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_cases();
    test_valid_dates(1100);
    test_bad_dates(280);
    test_back_to_back(250);
    in_valid <= 1'b0;
    while (pending_gaps.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_gaps.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
